// File: rtl/mfbc_pkg.sv
`default_nettype none
package mfbc_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 1048576;
  localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES + 2);
  localparam int unsigned OFF_W = 20;
  localparam int unsigned MIN_W = 16;
  localparam int unsigned MAX_W = 21;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [7:0] MRK_LEAD = 8'hFF;
  localparam logic [7:0] MRK_SOI = 8'hD8;
  localparam logic [7:0] MRK_EOI = 8'hD9;

  localparam logic [MIN_W-1:0] MIN_LEN_RESET = MIN_W'(16);
  localparam logic [MAX_W-1:0] MAX_LEN_RESET = MAX_W'(MAX_FRAME_BYTES);

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_TOO_LONG = 3'd1,
    ST_TOO_SHORT = 3'd2,
    ST_NO_START = 3'd3,
    ST_NO_END   = 3'd4
  } status_t;

  typedef struct packed {
    status_t          status;
    logic [POS_W-1:0] image_len;
    logic [POS_W-1:0] pad_len;
    logic             merged_found;
    logic [OFF_W-1:0] merged_off;
  } result_t;

endpackage
`default_nettype wire

// File: rtl/mfbc_in_stage.sv
`default_nettype none
module mfbc_in_stage
  import mfbc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_last_byte,
  input  wire logic       advance,
  output logic            s1_valid,
  output logic [7:0]      s1_byte,
  output logic            s1_last
);

  logic       valid_r;
  logic [7:0] byte_r;
  logic       last_r;

  assign in_ready = !valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      byte_r <= in_data_byte;
      last_r <= in_last_byte;
    end
  end

  assign s1_valid = valid_r;
  assign s1_byte  = byte_r;
  assign s1_last  = last_r;

endmodule
`default_nettype wire

// File: rtl/mfbc_scanner.sv
`default_nettype none
module mfbc_scanner
  import mfbc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             advance,
  input  wire logic [7:0]       data_byte,
  input  wire logic             last_byte,
  input  wire logic [MIN_W-1:0] min_len,
  input  wire logic [MAX_W-1:0] max_len,
  output result_t               result
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       prev_r, prev_nxt;
  logic             start_ok_r, start_ok_nxt;
  logic             end_seen_r, end_seen_nxt;
  logic [POS_W-1:0] end_len_r, end_len_nxt;
  logic             trail_seen_r, trail_seen_nxt;
  logic [OFF_W-1:0] trail_pos_r, trail_pos_nxt;

  logic             tracking;
  logic             lead;
  logic             soi_pair;
  logic             eoi_pair;
  logic             trail_hit;
  logic             eoi_hit;
  logic [POS_W-1:0] pos_m1;
  logic [POS_W-1:0] frame_len;

  always_comb begin
    tracking  = pos_r < POS_W'(MAX_FRAME_BYTES);
    lead      = prev_r == MRK_LEAD;
    soi_pair  = lead && (data_byte == MRK_SOI);
    eoi_pair  = lead && (data_byte == MRK_EOI);
    pos_m1    = pos_r - POS_W'(1);
    frame_len = pos_r + POS_W'(1);

    trail_hit = tracking && (pos_r != '0) && soi_pair && end_seen_r && !trail_seen_r
                && (pos_m1 >= end_len_r);
    eoi_hit   = tracking && (pos_r >= POS_W'(2)) && eoi_pair && !end_seen_r;

    start_ok_nxt   = start_ok_r || (tracking && (pos_r == POS_W'(1)) && soi_pair);
    trail_seen_nxt = trail_seen_r || trail_hit;
    trail_pos_nxt  = trail_hit ? pos_m1[OFF_W-1:0] : trail_pos_r;
    end_seen_nxt   = end_seen_r || eoi_hit;
    end_len_nxt    = eoi_hit ? frame_len : end_len_r;
    prev_nxt       = tracking ? data_byte : prev_r;
    pos_nxt        = tracking ? frame_len : pos_r;
  end

  always_comb begin
    result = '0;
    priority if ((frame_len > POS_W'(max_len)) || (frame_len > POS_W'(MAX_FRAME_BYTES))) begin
      result.status = ST_TOO_LONG;
    end else if (frame_len < POS_W'(min_len)) begin
      result.status = ST_TOO_SHORT;
    end else if (!start_ok_nxt) begin
      result.status = ST_NO_START;
    end else if (!end_seen_nxt) begin
      result.status = ST_NO_END;
    end else begin
      result.status       = ST_OK;
      result.image_len    = end_len_nxt;
      result.pad_len      = frame_len - end_len_nxt;
      result.merged_found = trail_seen_nxt;
      result.merged_off   = trail_seen_nxt ? trail_pos_nxt : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (advance && last_byte)) begin
      pos_r        <= '0;
      prev_r       <= '0;
      start_ok_r   <= 1'b0;
      end_seen_r   <= 1'b0;
      end_len_r    <= '0;
      trail_seen_r <= 1'b0;
      trail_pos_r  <= '0;
    end else if (advance) begin
      pos_r        <= pos_nxt;
      prev_r       <= prev_nxt;
      start_ok_r   <= start_ok_nxt;
      end_seen_r   <= end_seen_nxt;
      end_len_r    <= end_len_nxt;
      trail_seen_r <= trail_seen_nxt;
      trail_pos_r  <= trail_pos_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/mfbc_out_stage.sv
`default_nettype none
module mfbc_out_stage
  import mfbc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    load,
  input  wire result_t result,
  output logic         slot_free,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_result
);

  logic    valid_r;
  result_t result_r;

  assign slot_free = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (slot_free) begin
      valid_r <= load;
    end
    if (slot_free && load) begin
      result_r <= result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule
`default_nettype wire

// File: rtl/mjpeg_frame_boundary_checker.sv
// Channel  Direction  Handshake            Beat contents
// in       input      in_valid/in_ready    in_data_byte, in_last_byte
// out      output     out_valid/out_ready  out_frame_status, out_image_length,
//                                          out_padding_length, out_merged_start_*
// cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One byte is taken every cycle unless stalled; a beat passes an input register,
// then the marker scanner, and a result loads the output register with its last byte.
// Only the output register can stall the input, and only for a last byte.
// Reset is synchronous; it restores the length limits and clears the frame state.
// The configuration port is always ready.
`default_nettype none
module mjpeg_frame_boundary_checker
  import mfbc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [7:0]           in_data_byte,
  input  wire logic                 in_last_byte,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [2:0]                out_frame_status,
  output logic [20:0]               out_image_length,
  output logic [20:0]               out_padding_length,
  output logic                      out_merged_start_found,
  output logic [19:0]               out_merged_start_offset,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [MAX_W-1:0]     cfg_data
);

  logic [MIN_W-1:0] min_len_r;
  logic [MAX_W-1:0] max_len_r;
  logic             s1_valid;
  logic [7:0]       s1_byte;
  logic             s1_last;
  logic             advance;
  logic             slot_free;
  result_t          scan_result;
  result_t          out_result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= MIN_LEN_RESET;
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_MIN_LEN) begin
        min_len_r <= cfg_data[MIN_W-1:0];
      end
      if (cfg_index == CFG_MAX_LEN) begin
        max_len_r <= cfg_data;
      end
    end
  end

  assign advance = s1_valid && (!s1_last || slot_free);

  mfbc_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .advance      (advance),
    .s1_valid     (s1_valid),
    .s1_byte      (s1_byte),
    .s1_last      (s1_last)
  );

  mfbc_scanner u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .data_byte (s1_byte),
    .last_byte (s1_last),
    .min_len   (min_len_r),
    .max_len   (max_len_r),
    .result    (scan_result)
  );

  mfbc_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance && s1_last),
    .result     (scan_result),
    .slot_free  (slot_free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (out_result)
  );

  assign out_frame_status        = out_result.status;
  assign out_image_length        = out_result.image_len;
  assign out_padding_length      = out_result.pad_len;
  assign out_merged_start_found  = out_result.merged_found;
  assign out_merged_start_offset = out_result.merged_off;

endmodule
`default_nettype wire

// File: rtl/mfbc_checker.sv
`default_nettype none
module mfbc_checker
  import mfbc_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [2:0]           out_frame_status,
  input wire logic [20:0]          out_image_length,
  input wire logic [20:0]          out_padding_length,
  input wire logic                 out_merged_start_found,
  input wire logic [19:0]          out_merged_start_offset
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_status)
      && $stable(out_image_length) && $stable(out_padding_length))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat present straight after reset");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_frame_status != ST_OK) |->
      (out_image_length == '0) && (out_padding_length == '0)
      && !out_merged_start_found && (out_merged_start_offset == '0))
    else $error("failed frame carries non-zero lengths");

  a_ok_image: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_frame_status == ST_OK) |->
      (out_image_length >= 21'd3)
      && (!out_merged_start_found || (21'(out_merged_start_offset) >= out_image_length)))
    else $error("image length or merged start offset inconsistent");

  a_no_merge_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_merged_start_found |-> out_merged_start_offset == '0)
    else $error("merged start offset set without a merged start");

endmodule

bind mjpeg_frame_boundary_checker mfbc_checker u_mfbc_checker (.*);
`default_nettype wire
